// ----- rtl/smmc_pkg.sv -----
// Shared types and constants of the sensor min/max calibrator
package smmc_pkg;

  localparam int SampleBits  = 12;
  localparam int ChanBits    = 4;
  localparam int PercentBits = 16;
  localparam int Scale       = 100;
  localparam int ScaleBits   = 7;
  localparam int NumBits     = SampleBits + ScaleBits;
  localparam int CntBits     = $clog2(NumBits);
  localparam int PctMax      = 32767;
  localparam int PctMinMag   = 32768;

  localparam logic ActLearn     = 1'b0;
  localparam logic ActNormalize = 1'b1;

  typedef struct packed {
    logic                  action;
    logic [ChanBits-1:0]   channel;
    logic [SampleBits-1:0] sample;
  } item_t;

  typedef struct packed {
    logic signed [PercentBits-1:0] percent;
    logic                          range_invalid;
    logic [SampleBits-1:0]         low_bound;
    logic [SampleBits-1:0]         high_bound;
  } result_t;

  typedef struct packed {
    logic capture;
    logic fetch;
    logic evaluate;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic div_needed;
  } status_t;

endpackage

// ----- rtl/smmc_ram.sv -----
// Generic single-port-write, registered-read RAM
module smmc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 12
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/smmc_dpath.sv -----
// Datapath: item register, bound store, radix-2 divider and result register
module smmc_dpath #(
  parameter int NUM_CHANNELS = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  smmc_pkg::item_t   item_i,
  input  smmc_pkg::cmd_t    cmd_i,
  output smmc_pkg::status_t status_o,
  output smmc_pkg::result_t result_o
);

  localparam int SB = smmc_pkg::SampleBits;
  localparam int NW = smmc_pkg::NumBits;
  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int PB = smmc_pkg::PercentBits;

  smmc_pkg::item_t   item_q;
  smmc_pkg::result_t res_q, res_d;
  logic [NUM_CHANNELS-1:0] valid_q;
  logic [SB-1:0] den_q, den_d;
  logic [SB-1:0] rem_q, rem_d;
  logic [NW-1:0] quo_q, quo_d;
  logic          neg_q, neg_d;

  logic [AW+smmc_pkg::ChanBits-1:0] ch_ext;
  logic [AW-1:0]   addr;
  logic            in_range;
  logic            entry_valid;
  logic [2*SB-1:0] rdata;
  logic [SB-1:0]   lo, hi, new_lo, new_hi, mag;
  logic            learn, wr_en;
  logic [SB:0]     shifted, trial;
  logic [PB-1:0]   pct;

  assign ch_ext   = (AW + smmc_pkg::ChanBits)'(item_q.channel);
  assign addr     = ch_ext[AW-1:0];
  assign in_range = 32'(item_q.channel) < 32'(NUM_CHANNELS);
  assign learn    = (item_q.action == smmc_pkg::ActLearn);

  smmc_ram #(
    .WIDTH(2 * SB),
    .DEPTH(NUM_CHANNELS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(addr),
    .wdata_i({new_hi, new_lo}),
    .re_i   (cmd_i.fetch & in_range),
    .raddr_i(addr),
    .rdata_o(rdata)
  );

  // unlearned channels read as the reset bounds
  assign entry_valid = in_range & valid_q[addr];
  assign lo     = entry_valid ? rdata[SB-1:0] : {SB{1'b1}};
  assign hi     = entry_valid ? rdata[2*SB-1:SB] : '0;
  assign new_lo = (item_q.sample < lo) ? item_q.sample : lo;
  assign new_hi = (item_q.sample > hi) ? item_q.sample : hi;
  assign wr_en  = cmd_i.evaluate & in_range & learn;
  assign mag    = (item_q.sample < lo) ? (lo - item_q.sample) : (item_q.sample - lo);

  assign status_o.div_needed = ~learn & in_range & (hi > lo);

  assign shifted = {rem_q, quo_q[NW-1]};
  assign trial   = shifted - {1'b0, den_q};

  always_comb begin
    if (!neg_q) begin
      pct = (quo_q > NW'(smmc_pkg::PctMax)) ? PB'(smmc_pkg::PctMax) : quo_q[PB-1:0];
    end else begin
      pct = (quo_q > NW'(smmc_pkg::PctMinMag)) ? PB'(smmc_pkg::PctMinMag)
                                                : (~quo_q[PB-1:0] + PB'(1));
    end
  end

  always_comb begin
    res_d = res_q;
    den_d = den_q;
    rem_d = rem_q;
    quo_d = quo_q;
    neg_d = neg_q;
    if (cmd_i.evaluate) begin
      res_d.percent       = '0;
      res_d.range_invalid = ~learn & ~status_o.div_needed;
      res_d.low_bound     = in_range ? (learn ? new_lo : lo) : '0;
      res_d.high_bound    = in_range ? (learn ? new_hi : hi) : '0;
      den_d = hi - lo;
      rem_d = '0;
      quo_d = NW'(mag) * NW'(smmc_pkg::Scale);
      neg_d = item_q.sample < lo;
    end
    if (cmd_i.div_step) begin
      if (!trial[SB]) begin
        rem_d = trial[SB-1:0];
      end else begin
        rem_d = shifted[SB-1:0];
      end
      quo_d = {quo_q[NW-2:0], ~trial[SB]};
    end
    if (cmd_i.finish) begin
      res_d.percent = pct;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= item_i;
    end
    res_q <= res_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[addr] <= 1'b1;
    end
  end

  assign result_o = res_q;

endmodule

// ----- rtl/smmc_ctrl.sv -----
// Controller: sequences fetch, evaluate, divide and result strobe
module smmc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output logic              result_valid_o,
  input  smmc_pkg::status_t status_i,
  output smmc_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam int CB = smmc_pkg::CntBits;

  logic [2:0]    state_q, state_d;
  logic [CB-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE, S_DONE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d = S_FETCH;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.evaluate = 1'b1;
        cnt_d = '0;
        state_d = status_i.div_needed ? S_DIV : S_DONE;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + CB'(1);
        if (cnt_q == CB'(smmc_pkg::NumBits - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d = S_DONE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy           = ~((state_q == S_IDLE) || (state_q == S_DONE));
  assign result_valid_o = (state_q == S_DONE);

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("no busy after accepted transfer");
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (cnt_q <= CB'(smmc_pkg::NumBits - 1)))
    else $error("divider step count overrun");
  a_fin_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |-> ($past(state_q) == S_DIV))
    else $error("finish without divide");
`endif

endmodule

// ----- rtl/sensor_minmax_calibrator_top.sv -----
// Top level of the sensor min/max calibrator
// Usage:
//   Drive item_i (action, channel, sample) and raise start; the transfer is
//   taken at a rising edge with start high and busy low.
//   Learn widens the channel's stored bounds; normalize returns
//   (sample - min) * 100 / (max - min), truncated and saturated to 16 bits.
//   Each item gives one result on result_o, marked by result_valid_o for a
//   single cycle; the receiver cannot stall and must take it then.
// Sequence:
//   Learn, invalid range or unknown channel: accept, fetch, evaluate, strobe.
//   Normalize with a valid range: fetch, evaluate, then the one-bit-per-cycle
//   restoring divider over the 19-bit scaled numerator, finish, strobe.
//   A new item may be started in the cycle the strobe is shown.
// Reset:
//   Asynchronous, active low. All channels return to an empty range
//   (min 4095, max 0) through per-channel valid bits; no clearing pass.
module sensor_minmax_calibrator_top #(
  parameter int NUM_CHANNELS = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  smmc_pkg::item_t   item_i,
  output logic              result_valid_o,
  output smmc_pkg::result_t result_o
);

  smmc_pkg::cmd_t    cmd;
  smmc_pkg::status_t status;

  smmc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .result_valid_o(result_valid_o),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  smmc_dpath #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_dpath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_i),
    .cmd_i   (cmd),
    .status_o(status),
    .result_o(result_o)
  );

endmodule

// ----- tb/tb_sensor_minmax_calibrator_top.sv -----
// Self-checking testbench for the sensor min/max calibrator top level
`timescale 1ns / 1ps

module tb_sensor_minmax_calibrator_top;
  import smmc_pkg::*;

  localparam int NumChan    = 12;
  localparam int RandScans  = 1300;
  localparam int DrainWait  = 40;
  localparam int CycleLimit = 400000;
  localparam logic [SampleBits-1:0] SampleTop = '1;

  typedef struct {
    item_t       scan;
    int unsigned gap_pct;
  } pending_t;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    cmd_start = 1'b0;
  item_t   cmd_item = '0;
  logic    dut_busy;
  logic    res_strobe;
  result_t res_data;

  pending_t pending_scans[$];
  result_t  exp_results[$];

  logic [SampleBits-1:0] chan_min[NumChan];
  logic [SampleBits-1:0] chan_max[NumChan];
  int win_base[NumChan];

  int unsigned scans_sent = 0;
  int unsigned scans_total = 0;
  int unsigned results_checked = 0;
  int unsigned learn_count = 0;
  int unsigned norm_count = 0;
  int unsigned invalid_count = 0;
  int unsigned sat_count = 0;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;

  sensor_minmax_calibrator_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (cmd_start),
    .busy          (dut_busy),
    .item_i        (cmd_item),
    .result_valid_o(res_strobe),
    .result_o      (res_data)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Updates the tracked bounds and returns the result the block should give.
  function automatic result_t calibrate_expected(item_t it);
    result_t r;
    int num;
    int den;
    int q;
    r = '0;
    if (int'(it.channel) < NumChan) begin
      if (it.action == ActLearn) begin
        if (it.sample > chan_max[it.channel]) chan_max[it.channel] = it.sample;
        if (it.sample < chan_min[it.channel]) chan_min[it.channel] = it.sample;
      end else if (chan_max[it.channel] > chan_min[it.channel]) begin
        num = (int'(it.sample) - int'(chan_min[it.channel])) * Scale;
        den = int'(chan_max[it.channel]) - int'(chan_min[it.channel]);
        q = num / den;
        if (q > PctMax) q = PctMax;
        if (q < -PctMinMag) q = -PctMinMag;
        r.percent = q[PercentBits-1:0];
      end else begin
        r.range_invalid = 1'b1;
      end
      r.low_bound  = chan_min[it.channel];
      r.high_bound = chan_max[it.channel];
    end else if (it.action == ActNormalize) begin
      r.range_invalid = 1'b1;
    end
    return r;
  endfunction

  task automatic queue_scan(logic act, int ch, int smp, int unsigned gap);
    pending_t p;
    p.scan.action  = act;
    p.scan.channel = ch[ChanBits-1:0];
    p.scan.sample  = smp[SampleBits-1:0];
    p.gap_pct      = gap;
    pending_scans.push_back(p);
  endtask

  // Driver: one nonblocking update of start per edge
  always @(posedge clk_i or negedge rst_ni) begin : drive_scans
    logic taken;
    if (!rst_ni) begin
      cmd_start <= 1'b0;
      cmd_item  <= '0;
    end else begin
      taken = cmd_start && !dut_busy;
      if (taken) begin
        exp_results.push_back(calibrate_expected(cmd_item));
        void'(pending_scans.pop_front());
        scans_sent++;
      end
      if (cmd_start && !taken) begin
        // hold the transfer until it is taken
      end else if (pending_scans.size() > 0 &&
                   $urandom_range(0, 99) >= pending_scans[0].gap_pct) begin
        cmd_start <= 1'b1;
        cmd_item  <= pending_scans[0].scan;
      end else begin
        cmd_start <= 1'b0;
      end
    end
  end

  // Monitor and scoreboard
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && res_strobe) begin
      if (exp_results.size() == 0) begin
        $error("unexpected result: percent %0d low %0d high %0d",
               $signed(res_data.percent), res_data.low_bound, res_data.high_bound);
        err_count++;
      end else begin
        want = exp_results.pop_front();
        results_checked++;
        if (want.range_invalid) invalid_count++;
        if (want.percent == 16'sh7fff || want.percent == 16'sh8000) sat_count++;
        if (res_data.percent !== want.percent) begin
          $error("percent mismatch: expected %0d, got %0d",
                 $signed(want.percent), $signed(res_data.percent));
          err_count++;
        end
        if (res_data.range_invalid !== want.range_invalid) begin
          $error("range_invalid mismatch: expected %0b, got %0b",
                 want.range_invalid, res_data.range_invalid);
          err_count++;
        end
        if (res_data.low_bound !== want.low_bound) begin
          $error("low_bound mismatch: expected %0d, got %0d",
                 want.low_bound, res_data.low_bound);
          err_count++;
        end
        if (res_data.high_bound !== want.high_bound) begin
          $error("high_bound mismatch: expected %0d, got %0d",
                 want.high_bound, res_data.high_bound);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d of %0d transfers taken",
               cycle_count, scans_sent, scans_total);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned gap;
    int ch;
    int smp;
    logic act;
    for (int k = 0; k < NumChan; k++) begin
      chan_min[k] = SampleTop;
      chan_max[k] = '0;
      win_base[k] = $urandom_range(0, 4055);
    end
    win_base[4] = 0;
    win_base[5] = 4055;

    // directed: empty ranges, unknown channels, extremes, truncation, saturation
    queue_scan(ActNormalize, 0, 2048, 36);
    queue_scan(ActNormalize, 9, 4095, 36);
    queue_scan(ActLearn, 12, 4095, 36);
    queue_scan(ActNormalize, 15, 0, 36);
    queue_scan(ActLearn, 0, 0, 36);
    queue_scan(ActNormalize, 0, 0, 36);
    queue_scan(ActLearn, 0, 4095, 36);
    queue_scan(ActNormalize, 0, 0, 36);
    queue_scan(ActNormalize, 0, 4095, 36);
    queue_scan(ActNormalize, 0, 2048, 36);
    queue_scan(ActLearn, 1, 1000, 36);
    queue_scan(ActNormalize, 1, 1000, 36);
    queue_scan(ActLearn, 1, 1001, 36);
    queue_scan(ActNormalize, 1, 4095, 36);
    queue_scan(ActNormalize, 1, 0, 36);
    queue_scan(ActNormalize, 1, 999, 36);
    queue_scan(ActLearn, 10, 3000, 36);
    queue_scan(ActLearn, 10, 3003, 36);
    queue_scan(ActNormalize, 10, 3001, 36);
    queue_scan(ActLearn, 11, 0, 36);
    queue_scan(ActLearn, 11, 7, 36);
    queue_scan(ActNormalize, 11, 2, 36);
    queue_scan(ActLearn, 3, 10, 36);
    queue_scan(ActLearn, 3, 13, 36);
    queue_scan(ActNormalize, 3, 9, 36);

    // random: narrow per-channel windows so normalize hits the interior,
    // both saturation limits and the invalid-range path
    for (int n = 0; n < RandScans; n++) begin
      gap = (n < RandScans / 3) ? 36 : (n < 2 * RandScans / 3) ? 50 : 0;
      ch  = ($urandom_range(0, 99) < 10) ? $urandom_range(12, 15) : $urandom_range(0, 11);
      act = ($urandom_range(0, 99) < 35) ? ActLearn : ActNormalize;
      if (ch == 9) act = ActNormalize;
      if (ch >= NumChan) begin
        smp = $urandom_range(0, 4095);
      end else if (act == ActLearn) begin
        if (ch == 8) smp = win_base[8];
        else if ($urandom_range(0, 99) < 3) smp = $urandom_range(0, 4095);
        else smp = win_base[ch] + $urandom_range(0, 40);
      end else begin
        case ($urandom_range(0, 4))
          0, 1: begin
            smp = win_base[ch] + $urandom_range(0, 50) - 5;
            if (smp < 0) smp = 0;
            if (smp > 4095) smp = 4095;
          end
          2, 3: smp = $urandom_range(0, 4095);
          default: smp = $urandom_range(0, 1) ? 4095 : 0;
        endcase
      end
      queue_scan(act, ch, smp, gap);
      if (act == ActLearn) learn_count++;
      else norm_count++;
    end
    scans_total = pending_scans.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (scans_sent < scans_total || exp_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("%0d transfers taken, %0d results checked in %0d cycles",
             scans_sent, results_checked, cycle_count);
    $display("random mix: %0d learn, %0d normalize; %0d invalid range, %0d saturated",
             learn_count, norm_count, invalid_count, sat_count);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
